>>> design/hsi_pkg.sv
// Shared types for the heap sort block.
package hsi_pkg;

  localparam int unsigned DataW = 32;

  typedef logic signed [DataW-1:0] data_t;

  // Verdict of the shared compare unit for one sift step.
  typedef struct packed {
    logic take_right;  // right child is the smaller one
    logic move;        // smaller child sorts below the carried value
  } cmp_res_t;

endpackage

>>> design/hsi_mem.sv
// Element store: one write port, two read ports with registered read data.
module hsi_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  hsi_pkg::data_t       wdata_i,
  input  logic [AddrW-1:0]     raddr_a_i,
  input  logic [AddrW-1:0]     raddr_b_i,
  output hsi_pkg::data_t       rdata_a_o,
  output hsi_pkg::data_t       rdata_b_o
);
  import hsi_pkg::*;

  data_t mem_q [Depth];
  data_t rdata_a_q;
  data_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> design/hsi_cmp.sv
// Shared compare unit: picks the smaller child and decides whether it moves up.
module hsi_cmp (
  input  hsi_pkg::data_t   left_i,
  input  hsi_pkg::data_t   right_i,
  input  logic             right_ok_i,
  input  hsi_pkg::data_t   carried_i,
  output hsi_pkg::data_t   child_o,
  output hsi_pkg::cmp_res_t res_o
);
  import hsi_pkg::*;

  logic take_right;

  // ties keep the left child
  assign take_right       = right_ok_i && (right_i < left_i);
  assign child_o          = take_right ? right_i : left_i;
  assign res_o.take_right = take_right;
  assign res_o.move       = (child_o < carried_i);

endmodule

>>> design/heap_sort_int32.sv
// Heap sort top level: load, min-heap build, extraction and readout sequencer.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  input   | start_i, busy_o      | value_i, last_i
//  result  | result_valid_o       | sorted_value_o, final_res_o, dropped_o
//
// Loading takes a new item every clock while idle. After the last item the
// block is busy while it sorts: each sift-down level reads both children
// from the two-port store and compares them on the shared compare unit, then
// the sorted set is read out, one result a cycle. A one-element set goes
// straight to readout.
// Reset clears the control state only; the store needs no clearing.
// Results come out without any stall from the receiver.
module heap_sort_int32 #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  hsi_pkg::data_t value_i,
  input  logic           last_i,
  output logic           result_valid_o,
  output hsi_pkg::data_t sorted_value_o,
  output logic           final_res_o,
  output logic           dropped_o
);
  import hsi_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned KW = AW + 2;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_RDNODE  = 9'b000000010,
    S_GETNODE = 9'b000000100,
    S_RDKIDS  = 9'b000001000,
    S_CMP     = 9'b000010000,
    S_NEXT    = 9'b000100000,
    S_XRD     = 9'b001000000,
    S_XGET    = 9'b010000000,
    S_OEM     = 9'b100000000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] size_q, size_d;
  logic [AW-1:0] par_q, par_d;
  logic [AW-1:0] node_q, node_d;
  logic [AW-1:0] k_q, k_d;
  logic          build_q, build_d;
  data_t         cur_q, cur_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  data_t         mem_wdata;
  logic [AW-1:0] raddr_a, raddr_b;
  data_t         rdata_a, rdata_b;

  logic [KW-1:0] kid;
  logic [KW-1:0] kid_r;
  logic [KW-1:0] size_ext;
  logic          right_ok;
  data_t         child_val;
  cmp_res_t      cmp_res;
  logic          accept;
  logic          full;
  logic [CW-1:0] n_new;
  logic          is_final;

  hsi_mem #(
    .Depth (MAX_ELEMENTS),
    .AddrW (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  hsi_cmp u_cmp (
    .left_i     (rdata_a),
    .right_i    (rdata_b),
    .right_ok_i (right_ok),
    .carried_i  (cur_q),
    .child_o    (child_val),
    .res_o      (cmp_res)
  );

  assign kid      = {1'b0, node_q, 1'b1};
  assign kid_r    = kid + KW'(1);
  assign size_ext = KW'(size_q);
  assign right_ok = kid_r < size_ext;
  assign accept   = start_i && (state_q == S_IDLE);
  assign full     = (count_q == CW'(MAX_ELEMENTS));
  assign n_new    = full ? count_q : count_q + CW'(1);
  assign is_final = (CW'(k_q) + CW'(1)) == count_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    size_d    = size_q;
    par_d     = par_q;
    node_d    = node_q;
    k_d       = k_q;
    build_d   = build_q;
    cur_d     = cur_q;
    mem_we    = 1'b0;
    mem_waddr = node_q;
    mem_wdata = cur_q;
    raddr_a   = node_q;
    raddr_b   = AW'(kid_r);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = count_q[AW-1:0];
            mem_wdata = value_i;
          end
          count_d = n_new;
          if (last_i) begin
            k_d = '0;
            if (n_new == CW'(1)) begin
              // entry 0 is being written now; S_NEXT reads it back for readout
              size_d  = n_new;
              build_d = 1'b0;
              state_d = S_NEXT;
            end else begin
              size_d  = n_new;
              par_d   = AW'((n_new >> 1) - CW'(1));
              node_d  = AW'((n_new >> 1) - CW'(1));
              build_d = 1'b1;
              state_d = S_RDNODE;
            end
          end
        end
      end
      S_RDNODE: begin
        raddr_a = node_q;
        state_d = S_GETNODE;
      end
      S_GETNODE: begin
        cur_d   = rdata_a;
        state_d = S_RDKIDS;
      end
      S_RDKIDS: begin
        if (kid >= size_ext) begin
          // leaf reached: drop the carried value into the hole
          mem_we  = 1'b1;
          state_d = S_NEXT;
        end else begin
          raddr_a = AW'(kid);
          raddr_b = AW'(kid_r);
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        mem_we = 1'b1;
        if (cmp_res.move) begin
          mem_wdata = child_val;
          node_d    = cmp_res.take_right ? AW'(kid_r) : AW'(kid);
          state_d   = S_RDKIDS;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (build_q) begin
          if (par_q == '0) begin
            build_d = 1'b0;
            state_d = S_XRD;
          end else begin
            par_d   = par_q - AW'(1);
            node_d  = par_q - AW'(1);
            state_d = S_RDNODE;
          end
        end else if (size_q > CW'(1)) begin
          state_d = S_XRD;
        end else begin
          k_d     = '0;
          raddr_a = '0;
          state_d = S_OEM;
        end
      end
      S_XRD: begin
        raddr_a = '0;
        raddr_b = AW'(size_q - CW'(1));
        state_d = S_XGET;
      end
      S_XGET: begin
        // old root goes to the tail, tail value sifts down from the root
        mem_we    = 1'b1;
        mem_waddr = AW'(size_q - CW'(1));
        mem_wdata = rdata_a;
        cur_d     = rdata_b;
        node_d    = '0;
        size_d    = size_q - CW'(1);
        state_d   = S_RDKIDS;
      end
      S_OEM: begin
        if (is_final) begin
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = S_IDLE;
        end else begin
          k_d     = k_q + AW'(1);
          raddr_a = k_q + AW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
      size_q  <= '0;
      par_q   <= '0;
      node_q  <= '0;
      k_q     <= '0;
      build_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      size_q  <= size_d;
      par_q   <= par_d;
      node_q  <= node_d;
      k_q     <= k_d;
      build_q <= build_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_OEM);
  assign sorted_value_o = rdata_a;
  assign final_res_o    = result_valid_o && is_final;
  assign dropped_o      = result_valid_o && ovf_q;

endmodule

>>> design/hsi_chk.sv
// Port-level checks for the heap sort block, bound to the top level.
module hsi_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input hsi_pkg::data_t value_i,
  input logic           last_i,
  input logic           result_valid_o,
  input hsi_pkg::data_t sorted_value_o,
  input logic           final_res_o,
  input logic           dropped_o
);
  import hsi_pkg::*;

  // results only come out of a sort in progress
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result strobe while idle");

  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    final_res_o |=> !busy_o)
    else $error("block still busy after final result");

  a_plain_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !last_i) |=> (!busy_o && !result_valid_o))
    else $error("non-last item did not leave the block ready");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_i) |=> busy_o)
    else $error("last item did not start a sort");

  a_flags_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (final_res_o || dropped_o) |-> result_valid_o)
    else $error("result flag without strobe");

endmodule

bind heap_sort_int32 hsi_chk u_hsi_chk (.*);
